[design/okvt_pkg.sv]
// shared types and constants for the ordered key/value table
// no dependencies; imported by every module of the block
package okvt_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    // widths of the fixed stream fields
    localparam int FIELD_W    = 64;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 2 * FIELD_W;
    localparam int OUT_PAY_W  = 2 * FIELD_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_SEARCH = 2'd1,
        K_REMOVE = 2'd2,
        K_DUMP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DUMP
    } state_t;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        C_HOLD,
        C_LOAD,
        C_KEEP,
        C_DROP
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] tail_idx;
    } cell_ctl_t;

    typedef struct packed {
        state_t           state;
        logic [CNT_W-1:0] occ;
        logic [CNT_W-1:0] steps;
    } ctl_status_t;

endpackage

[design/okvt_cell.sv]
// one storage cell of the table chain: a key/value pair
// depends on okvt_pkg
module okvt_cell
    import okvt_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      idx,
    input  cell_ctl_t             ctl,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic [KEY_BITS-1:0]   nb_key,
    input  logic [VALUE_BITS-1:0] nb_value,
    input  logic [KEY_BITS-1:0]   head_key,
    input  logic [VALUE_BITS-1:0] head_value,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        unique case (ctl.op)
            C_HOLD:
            begin
            end
            C_LOAD:
            begin
                if (idx == ctl.wr_idx)
                begin
                    key_next   = new_key;
                    value_next = new_value;
                end
            end
            C_KEEP:
            begin
                // rotate inside the window: the head wraps to the tail
                if (idx == ctl.tail_idx)
                begin
                    key_next   = head_key;
                    value_next = head_value;
                end
                else if (idx < ctl.tail_idx)
                begin
                    key_next   = nb_key;
                    value_next = nb_value;
                end
            end
            C_DROP:
            begin
                // head falls out, window shrinks by one
                if (idx < ctl.tail_idx)
                begin
                    key_next   = nb_key;
                    value_next = nb_value;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

[design/okvt_ctrl.sv]
// sequencer of the table: occupancy, scan counter, match capture, result register
// depends on okvt_pkg; drives the cell chain through cell_ctl_t
module okvt_ctrl
    import okvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_kind,
    input  logic [FIELD_W-1:0]    in_key,
    input  logic [FIELD_W-1:0]    in_value,
    input  logic [KEY_BITS-1:0]   head_key,
    input  logic [VALUE_BITS-1:0] head_value,
    output cell_ctl_t             ctl,
    output logic [KEY_BITS-1:0]   new_key,
    output logic [VALUE_BITS-1:0] new_value,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [1:0]            res_status,
    output logic [FIELD_W-1:0]    res_key,
    output logic [FIELD_W-1:0]    res_value,
    output logic [COUNT_W-1:0]    res_count,
    output logic                  res_last,
    output ctl_status_t           status
);

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      occ_reg;
    logic [CNT_W-1:0]      occ_next;
    logic [CNT_W-1:0]      steps_reg;
    logic [CNT_W-1:0]      steps_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  rem_reg;
    logic                  rem_next;
    logic [KEY_BITS-1:0]   skey_reg;
    logic [KEY_BITS-1:0]   skey_next;
    logic [KEY_BITS-1:0]   mkey_reg;
    logic [KEY_BITS-1:0]   mkey_next;
    logic [VALUE_BITS-1:0] mval_reg;
    logic [VALUE_BITS-1:0] mval_next;

    logic                  ov_reg;
    logic                  ov_next;
    logic [1:0]            ost_reg;
    logic [1:0]            ost_next;
    logic [FIELD_W-1:0]    okey_reg;
    logic [FIELD_W-1:0]    okey_next;
    logic [FIELD_W-1:0]    oval_reg;
    logic [FIELD_W-1:0]    oval_next;
    logic [CNT_W-1:0]      ocnt_reg;
    logic [CNT_W-1:0]      ocnt_next;
    logic                  olast_reg;
    logic                  olast_next;

    logic                  out_free;
    logic                  accept;
    logic                  head_hit;
    logic [CNT_W-1:0]      occ_dec;
    logic [CNT_W-1:0]      occ_inc;
    kind_t                 kind;

    assign out_free = !ov_reg || res_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign head_hit = (head_key == skey_reg);
    assign occ_dec  = occ_reg - 1'b1;
    assign occ_inc  = occ_reg + 1'b1;
    assign kind     = kind_t'(in_kind);

    assign new_key   = in_key[KEY_BITS-1:0];
    assign new_value = in_value[VALUE_BITS-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        K_ADD:    state_next = S_IDLE;
                        K_SEARCH: state_next = S_SCAN;
                        K_REMOVE: state_next = S_SCAN;
                        K_DUMP:   state_next = (occ_reg == '0) ? S_IDLE : S_DUMP;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (steps_reg == '0 && out_free)
                    state_next = S_IDLE;
            end
            S_DUMP:
            begin
                if (out_free && steps_reg == CNT_W'(1))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        occ_next    = occ_reg;
        steps_next  = steps_reg;
        hit_next    = hit_reg;
        rem_next    = rem_reg;
        skey_next   = skey_reg;
        mkey_next   = mkey_reg;
        mval_next   = mval_reg;
        ov_next     = ov_reg && !res_ready;
        ost_next    = ost_reg;
        okey_next   = okey_reg;
        oval_next   = oval_reg;
        ocnt_next   = ocnt_reg;
        olast_next  = olast_reg;
        ctl.op       = C_HOLD;
        ctl.wr_idx   = occ_reg[IDX_W-1:0];
        ctl.tail_idx = occ_dec[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        K_ADD:
                        begin
                            ov_next    = 1'b1;
                            okey_next  = '0;
                            oval_next  = '0;
                            olast_next = 1'b1;
                            if (occ_reg >= CNT_W'(CAPACITY))
                            begin
                                ost_next  = ST_FULL;
                                ocnt_next = occ_reg;
                            end
                            else
                            begin
                                ctl.op    = C_LOAD;
                                occ_next  = occ_inc;
                                ost_next  = ST_OK;
                                ocnt_next = occ_inc;
                            end
                        end
                        K_SEARCH, K_REMOVE:
                        begin
                            skey_next  = in_key[KEY_BITS-1:0];
                            steps_next = occ_reg;
                            hit_next   = 1'b0;
                            rem_next   = (kind == K_REMOVE);
                        end
                        K_DUMP:
                        begin
                            steps_next = occ_reg;
                            if (occ_reg == '0)
                            begin
                                ov_next    = 1'b1;
                                ost_next   = ST_EMPTY;
                                okey_next  = '0;
                                oval_next  = '0;
                                ocnt_next  = occ_reg;
                                olast_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (steps_reg != '0)
                begin
                    steps_next = steps_reg - 1'b1;
                    if (!hit_reg && head_hit)
                    begin
                        hit_next  = 1'b1;
                        mkey_next = head_key;
                        mval_next = head_value;
                        if (rem_reg)
                        begin
                            ctl.op   = C_DROP;
                            occ_next = occ_dec;
                        end
                        else
                            ctl.op = C_KEEP;
                    end
                    else
                        ctl.op = C_KEEP;
                end
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = hit_reg ? ST_OK : ST_MISS;
                    okey_next  = (hit_reg && !rem_reg) ? FIELD_W'(mkey_reg) : '0;
                    oval_next  = (hit_reg && !rem_reg) ? FIELD_W'(mval_reg) : '0;
                    ocnt_next  = occ_reg;
                    olast_next = 1'b1;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    ctl.op     = C_KEEP;
                    steps_next = steps_reg - 1'b1;
                    ov_next    = 1'b1;
                    ost_next   = ST_OK;
                    okey_next  = FIELD_W'(head_key);
                    oval_next  = FIELD_W'(head_value);
                    ocnt_next  = occ_reg;
                    olast_next = (steps_reg == CNT_W'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            steps_reg <= '0;
            hit_reg   <= 1'b0;
            rem_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            steps_reg <= steps_next;
            hit_reg   <= hit_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skey_reg  <= skey_next;
        mkey_reg  <= mkey_next;
        mval_reg  <= mval_next;
        ost_reg   <= ost_next;
        okey_reg  <= okey_next;
        oval_reg  <= oval_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign res_valid  = ov_reg;
    assign res_status = ost_reg;
    assign res_key    = okey_reg;
    assign res_value  = oval_reg;
    assign res_count  = COUNT_W'(ocnt_reg);
    assign res_last   = olast_reg;

    assign status.state = state_reg;
    assign status.occ   = occ_reg;
    assign status.steps = steps_reg;

endmodule

[design/ordered_key_value_table_unit.sv]
// top level of the ordered key/value table: stream ports, cell chain, sequencer
// depends on okvt_pkg, okvt_cell, okvt_ctrl
//
// Fixed-capacity table of key/value pairs kept in insertion order, held in a
// chain of CAPACITY cells that can rotate their live window by one place per
// cycle, with the head cell (entry 0) watched by the sequencer. An add writes
// straight into the cell after the last entry; full is reported when CAPACITY
// entries are held. A search or remove rotates the window once around, comparing
// the head key each cycle, then loads its result once the result register is
// free; remove lets the first matching head fall out of the window, which keeps
// the remaining order. A dump emits one transfer per entry from the head while
// rotating, moving on only while the result register is free, or a single empty
// status when the table holds nothing. Only one item is in work at a time; a new
// item is taken only when the result register is empty or its result leaves in
// the same cycle. Duplicate keys are allowed; search and remove act on the lowest
// index. Every result carries the entry count after the operation.
module ordered_key_value_table_unit
    import okvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key [63:0], value [127:64]
    input  logic [1:0]            s_tuser,   // kind [1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_key [63:0], out_value [127:64],
                                             // count [134:128], zero pad [135]
    output logic [1:0]            m_tuser,   // status [1:0]
    output logic                  m_tlast    // final transfer of the item
);

    // chain wiring: one key/value pair per cell
    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];

    cell_ctl_t             ctl;
    ctl_status_t           status;
    logic [KEY_BITS-1:0]   new_key;
    logic [VALUE_BITS-1:0] new_value;
    logic [FIELD_W-1:0]    res_key;
    logic [FIELD_W-1:0]    res_value;
    logic [COUNT_W-1:0]    res_count;

    okvt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_key     (s_tdata[FIELD_W-1:0]),
        .in_value   (s_tdata[2*FIELD_W-1:FIELD_W]),
        .head_key   (cell_key[0]),
        .head_value (cell_value[0]),
        .ctl        (ctl),
        .new_key    (new_key),
        .new_value  (new_value),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (m_tuser),
        .res_key    (res_key),
        .res_value  (res_value),
        .res_count  (res_count),
        .res_last   (m_tlast),
        .status     (status)
    );

    // each cell takes from its upper neighbor; the top cell has none and
    // is never asked to shift from it
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [KEY_BITS-1:0]   nb_key;
            logic [VALUE_BITS-1:0] nb_value;

            if (gi == CAPACITY - 1)
            begin : g_top
                assign nb_key   = cell_key[gi];
                assign nb_value = cell_value[gi];
            end
            else
            begin : g_mid
                assign nb_key   = cell_key[gi+1];
                assign nb_value = cell_value[gi+1];
            end

            okvt_cell u_cell (
                .clk        (clk),
                .idx        (IDX_W'(gi)),
                .ctl        (ctl),
                .new_key    (new_key),
                .new_value  (new_value),
                .nb_key     (nb_key),
                .nb_value   (nb_value),
                .head_key   (cell_key[0]),
                .head_value (cell_value[0]),
                .key        (cell_key[gi]),
                .value      (cell_value[gi])
            );
        end
    endgenerate

    assign m_tdata = OUT_DATA_W'({res_count, res_value, res_key});

    // occupancy never passes the capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.occ <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // occupancy moves by at most one entry per cycle
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (status.occ == $past(status.occ)
               || status.occ == $past(status.occ) + 1'b1
               || status.occ + 1'b1 == $past(status.occ)))
        else $error("occupancy jumped");

    // a dump in progress always has entries left to send within the table
    a_dump_steps: assert property (@(posedge clk) disable iff (!rst_n)
        status.state == S_DUMP |-> (status.steps != '0 && status.steps <= status.occ))
        else $error("dump counter out of range");

    // input is only taken when the result register can take a result
    a_in_gate: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while result register blocked");

endmodule
